/* design/svp_pkg.sv */
// shared types and constants for the source visibility predictor
// no dependencies; imported by every design file except svp_ram
package svp_pkg;

	// input word: load or predict command
	typedef struct packed {
		logic               op;
		logic [7:0]         chan;
		logic [1:0]         pol_in;
		logic signed [23:0] bright_re;
		logic signed [23:0] bright_im;
		logic signed [31:0] coord_u;
		logic signed [31:0] coord_v;
		logic signed [31:0] coord_w;
	} svp_in_t;

	// result word: one polarization of a predicted visibility
	typedef struct packed {
		logic [1:0]         pol_out;
		logic signed [23:0] vis_re;
		logic signed [23:0] vis_im;
		logic               last;
	} svp_out_t;

	typedef enum logic [2:0] {
		REG_POS_L       = 3'd0,
		REG_POS_M       = 3'd1,
		REG_POS_N1      = 3'd2,
		REG_GAUSS_T0    = 3'd3,
		REG_GAUSS_T1    = 3'd4,
		REG_GAUSS_T2    = 3'd5,
		REG_GAUSS_T3    = 3'd6,
		REG_SOURCE_KIND = 3'd7
	} svp_reg_t;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_PREDICT = 1'b1;

	localparam int CORDIC_STEPS = 28;
	localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
	localparam logic signed [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
		32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
		32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
		32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
		32'sd652, 32'sd326, 32'sd163, 32'sd81,
		32'sd41, 32'sd20, 32'sd10, 32'sd5
	};

	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0] LN2_Q30   = 30'd744261118;
	localparam logic [30:0] ONE_Q30   = 31'd1073741824;

	// series terms of exp and floor(2^31 / n) for the divide by n
	localparam int TAYLOR_TERMS = 13;
	localparam logic [31:0] RECIP [TAYLOR_TERMS] = '{
		32'd2147483648, 32'd1073741824, 32'd715827882, 32'd536870912,
		32'd429496729, 32'd357913941, 32'd306783378, 32'd268435456,
		32'd238609294, 32'd214748364, 32'd195225786, 32'd178956970,
		32'd165191049
	};

	// pipeline depths, counted from the registered input word
	localparam int PHASE_LAT  = 3;
	localparam int CORDIC_LAT = CORDIC_STEPS + 2;
	localparam int TAPER_LAT  = 6 + 3 * TAYLOR_TERMS + 1;
	localparam int CORDIC_PAD = TAPER_LAT - PHASE_LAT - CORDIC_LAT;

endpackage

/* design/svp_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module svp_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/svp_cordic.sv */
// pipelined cordic: phase in turns to cosine and sine in q30
// depends on svp_pkg
module svp_cordic (
	input  logic               clk,
	input  logic [31:0]        phase,
	output logic signed [31:0] cos_val,
	output logic signed [31:0] sin_val
);
	import svp_pkg::*;

	localparam int W = 34;
	localparam logic signed [W-1:0] QUARTER = 34'sd1073741824;
	localparam logic signed [W-1:0] HALF    = 34'sd2147483648;

	logic signed [W-1:0] x_q [CORDIC_STEPS+1];
	logic signed [W-1:0] y_q [CORDIC_STEPS+1];
	logic signed [W-1:0] z_q [CORDIC_STEPS+1];
	logic                neg_q [CORDIC_STEPS+1];

	logic signed [W-1:0] p_ext;
	logic signed [W-1:0] z0;
	logic                neg0;

	// fold into the right half plane
	always_comb begin
		p_ext = W'(signed'(phase));
		z0    = p_ext;
		neg0  = 1'b0;
		if (p_ext > QUARTER) begin
			z0   = p_ext - HALF;
			neg0 = 1'b1;
		end else if (p_ext < -QUARTER) begin
			z0   = p_ext + HALF;
			neg0 = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		x_q[0]   <= W'(CORDIC_GAIN_Q30);
		y_q[0]   <= '0;
		z_q[0]   <= z0;
		neg_q[0] <= neg0;
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			neg_q[i+1] <= neg_q[i];
			if (!z_q[i][W-1]) begin
				x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
				y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
				z_q[i+1] <= z_q[i] - W'(ATAN_TURNS[i]);
			end else begin
				x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
				y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
				z_q[i+1] <= z_q[i] + W'(ATAN_TURNS[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		cos_val <= 32'(neg_q[CORDIC_STEPS] ? -x_q[CORDIC_STEPS] : x_q[CORDIC_STEPS]);
		sin_val <= 32'(neg_q[CORDIC_STEPS] ? -y_q[CORDIC_STEPS] : y_q[CORDIC_STEPS]);
	end

endmodule

/* design/svp_taper.sv */
// pipelined gaussian taper exp(-(ut^2+vt^2)) in q30
// depends on svp_pkg
module svp_taper (
	input  logic               clk,
	input  logic signed [31:0] coord_u,
	input  logic signed [31:0] coord_v,
	input  logic signed [31:0] gauss_t0,
	input  logic signed [31:0] gauss_t1,
	input  logic signed [31:0] gauss_t2,
	input  logic signed [31:0] gauss_t3,
	output logic [30:0]        taper
);
	import svp_pkg::*;

	localparam logic signed [32:0] LIM    = 33'sd268435456;
	localparam logic signed [29:0] LIM_30 = 30'sd268435456;

	// transform products, upper halves
	logic signed [63:0] m0, m1, m2, m3;
	logic signed [31:0] a0_q, a1_q, a2_q, a3_q;
	assign m0 = coord_u * gauss_t0;
	assign m1 = coord_v * gauss_t1;
	assign m2 = coord_u * gauss_t2;
	assign m3 = coord_v * gauss_t3;

	always_ff @(posedge clk) begin
		a0_q <= m0[63:32];
		a1_q <= m1[63:32];
		a2_q <= m2[63:32];
		a3_q <= m3[63:32];
	end

	// sum and clamp to +-16.0
	logic signed [32:0] su, sv;
	logic signed [29:0] ut_c, vt_c, ut_q, vt_q;
	always_comb begin
		su = 33'(a0_q) + 33'(a1_q);
		sv = 33'(a2_q) + 33'(a3_q);
		if (su > LIM) ut_c = LIM_30;
		else if (su < -LIM) ut_c = -LIM_30;
		else ut_c = 30'(su);
		if (sv > LIM) vt_c = LIM_30;
		else if (sv < -LIM) vt_c = -LIM_30;
		else vt_c = 30'(sv);
	end

	always_ff @(posedge clk) begin
		ut_q <= ut_c;
		vt_q <= vt_c;
	end

	// squares
	logic signed [59:0] squ, sqv;
	logic [56:0] squ_q, sqv_q;
	assign squ = ut_q * ut_q;
	assign sqv = vt_q * vt_q;

	always_ff @(posedge clk) begin
		squ_q <= squ[56:0];
		sqv_q <= sqv[56:0];
	end

	// q in q24, out of range at 32.0
	logic [57:0] qs;
	logic [28:0] q_q;
	logic        big_q;
	assign qs = 58'(squ_q) + 58'(sqv_q);

	always_ff @(posedge clk) begin
		q_q   <= qs[52:24];
		big_q <= |qs[57:53];
	end

	// base-2 exponent
	logic [59:0] yp;
	logic [29:0] y_q;
	logic        big_e_q;
	assign yp = q_q * LOG2E_Q30;

	always_ff @(posedge clk) begin
		y_q     <= yp[59:30];
		big_e_q <= big_q;
	end

	// split into shift and fraction, fraction back to natural argument
	logic [5:0]  k_int;
	logic [59:0] tp;
	assign k_int = y_q[29:24];
	assign tp    = {y_q[23:0], 6'd0} * LN2_Q30;

	logic [30:0]        tm [TAYLOR_TERMS+1];
	logic signed [31:0] ac [TAYLOR_TERMS+1];
	logic [29:0]        tt [TAYLOR_TERMS+1];
	logic [4:0]         kk [TAYLOR_TERMS+1];
	logic               zz [TAYLOR_TERMS+1];

	always_ff @(posedge clk) begin
		tm[0] <= ONE_Q30;
		ac[0] <= 32'(ONE_Q30);
		tt[0] <= tp[59:30];
		kk[0] <= k_int[4:0];
		zz[0] <= big_e_q | (k_int >= 6'd31);
	end

	// one series term per three stages: multiply, reciprocal, correct
	for (genvar j = 0; j < TAYLOR_TERMS; j++) begin : g_term
		localparam int N = j + 1;

		logic [60:0]        prod;
		logic [29:0]        x_a, x_b, qa_b, q_c;
		logic [61:0]        pq;
		logic [33:0]        qn, r;
		logic signed [31:0] ac_a, ac_b;
		logic [29:0]        tt_a, tt_b;
		logic [4:0]         kk_a, kk_b;
		logic               zz_a, zz_b;

		assign prod = tm[j] * tt[j];

		always_ff @(posedge clk) begin
			x_a  <= prod[59:30];
			ac_a <= ac[j];
			tt_a <= tt[j];
			kk_a <= kk[j];
			zz_a <= zz[j];
		end

		assign pq = x_a * RECIP[j];

		always_ff @(posedge clk) begin
			qa_b <= pq[60:31];
			x_b  <= x_a;
			ac_b <= ac_a;
			tt_b <= tt_a;
			kk_b <= kk_a;
			zz_b <= zz_a;
		end

		// estimate is low by at most one
		always_comb begin
			qn  = 34'(qa_b) * 34'(N);
			r   = 34'(x_b) - qn;
			q_c = (r >= 34'(N)) ? qa_b + 30'd1 : qa_b;
		end

		always_ff @(posedge clk) begin
			tm[j+1] <= 31'(q_c);
			if (N % 2 == 1) begin
				ac[j+1] <= ac_b - signed'(32'(q_c));
			end else begin
				ac[j+1] <= ac_b + signed'(32'(q_c));
			end
			tt[j+1] <= tt_b;
			kk[j+1] <= kk_b;
			zz[j+1] <= zz_b;
		end
	end

	always_ff @(posedge clk) begin
		taper <= zz[TAYLOR_TERMS] ? '0 : 31'($unsigned(ac[TAYLOR_TERMS]) >> kk[TAYLOR_TERMS]);
	end

endmodule

/* design/source_visibility_predictor.sv */
// visibility predictor for one point or gaussian sky component
// depends on svp_pkg, svp_ram, svp_cordic, svp_taper
// throughput: one load word per cycle while busy is low; a predict holds busy so that
// the single result port can emit its four words per predict without overlap
// loads reach the brightness table through the word delay line, in order with predicts
// reset clears control and configuration; the brightness table is not cleared
module source_visibility_predictor #(
	parameter int CHANNELS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  svp_pkg::svp_in_t  item,
	output logic              res_strobe,
	output svp_pkg::svp_out_t res,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	import svp_pkg::*;

	localparam int AW = $clog2(CHANNELS * 4);

	// fields of a word that travel to the table stage
	typedef struct packed {
		logic               op;
		logic [7:0]         chan;
		logic [1:0]         pol;
		logic signed [23:0] re;
		logic signed [23:0] im;
	} item_t;

	// side information that follows each table read
	typedef struct packed {
		logic [1:0]  pol;
		logic        inr;
		logic [30:0] tap;
	} tag_t;

	// ---------------- configuration registers ----------------
	logic signed [30:0] reg_l_q, reg_m_q, reg_n1_q;
	logic signed [31:0] reg_t_q [4];
	logic               kind_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_l_q  <= '0;
			reg_m_q  <= '0;
			reg_n1_q <= '0;
			for (int i = 0; i < 4; i++) reg_t_q[i] <= '0;
			kind_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (svp_reg_t'(cfg_index))
				REG_POS_L:       reg_l_q    <= cfg_data[30:0];
				REG_POS_M:       reg_m_q    <= cfg_data[30:0];
				REG_POS_N1:      reg_n1_q   <= cfg_data[30:0];
				REG_GAUSS_T0:    reg_t_q[0] <= cfg_data;
				REG_GAUSS_T1:    reg_t_q[1] <= cfg_data;
				REG_GAUSS_T2:    reg_t_q[2] <= cfg_data;
				REG_GAUSS_T3:    reg_t_q[3] <= cfg_data;
				REG_SOURCE_KIND: kind_q     <= cfg_data[0];
			endcase
		end
	end

	// ---------------- input acceptance ----------------
	// a predict raises busy for a while so result bursts never overlap
	logic       accept;
	logic [1:0] busy_cnt_q;
	assign accept = start & ~busy;
	assign busy   = (busy_cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_cnt_q <= 2'd0;
		end else if (accept && item.op == OP_PREDICT) begin
			busy_cnt_q <= 2'd3;
		end else if (busy) begin
			busy_cnt_q <= busy_cnt_q - 2'd1;
		end
	end

	svp_in_t in_s1;
	logic    v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) in_s1 <= item;
	end

	// ---------------- phase in turns ----------------
	// only the low 46 bits matter: the phase wraps at one turn (2^46)
	logic signed [62:0] pl, pm, pn;
	logic [45:0]        pl_s2, pm_s2, pn_s2, sab_s3, pn_s3, psum;
	logic [31:0]        phase_s4;
	assign pl   = in_s1.coord_u * reg_l_q;
	assign pm   = in_s1.coord_v * reg_m_q;
	assign pn   = in_s1.coord_w * reg_n1_q;
	assign psum = sab_s3 + pn_s3;

	always_ff @(posedge clk) begin
		pl_s2    <= pl[45:0];
		pm_s2    <= pm[45:0];
		pn_s2    <= pn[45:0];
		sab_s3   <= pl_s2 + pm_s2;
		pn_s3    <= pn_s2;
		phase_s4 <= psum[45:14];
	end

	logic signed [31:0] cos_c, sin_c;

	svp_cordic u_cordic (
		.clk     (clk),
		.phase   (phase_s4),
		.cos_val (cos_c),
		.sin_val (sin_c)
	);

	// cordic is shorter than the taper: pad to line up at the table stage
	logic signed [31:0] cos_pad [CORDIC_PAD];
	logic signed [31:0] sin_pad [CORDIC_PAD];

	always_ff @(posedge clk) begin
		cos_pad[0] <= cos_c;
		sin_pad[0] <= sin_c;
		for (int i = 1; i < CORDIC_PAD; i++) begin
			cos_pad[i] <= cos_pad[i-1];
			sin_pad[i] <= sin_pad[i-1];
		end
	end

	logic [30:0] taper_c;

	svp_taper u_taper (
		.clk      (clk),
		.coord_u  (in_s1.coord_u),
		.coord_v  (in_s1.coord_v),
		.gauss_t0 (reg_t_q[0]),
		.gauss_t1 (reg_t_q[1]),
		.gauss_t2 (reg_t_q[2]),
		.gauss_t3 (reg_t_q[3]),
		.taper    (taper_c)
	);

	// ---------------- word delay line ----------------
	// loads travel with predicts so the table sees every word in order
	item_t dl [TAPER_LAT];
	logic  vl [TAPER_LAT];

	always_ff @(posedge clk) begin
		dl[0] <= '{op: in_s1.op, chan: in_s1.chan, pol: in_s1.pol_in,
			re: in_s1.bright_re, im: in_s1.bright_im};
		for (int i = 1; i < TAPER_LAT; i++) dl[i] <= dl[i-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPER_LAT; i++) vl[i] <= 1'b0;
		end else begin
			vl[0] <= v_s1;
			for (int i = 1; i < TAPER_LAT; i++) vl[i] <= vl[i-1];
		end
	end

	// ---------------- table stage ----------------
	item_t xi;
	logic  xv, x_inr, x_load, x_pred;
	assign xi     = dl[TAPER_LAT-1];
	assign xv     = vl[TAPER_LAT-1];
	assign x_inr  = (32'(xi.chan) < CHANNELS);
	assign x_load = xv && (xi.op == OP_LOAD) && x_inr;
	assign x_pred = xv && (xi.op == OP_PREDICT);

	// read sequencer: four entries of the channel, pol 0 first
	logic               act_q;
	logic [1:0]         cnt_q;
	logic [7:0]         chan_q;
	logic               inr_q;
	logic [30:0]        tap_q;
	logic signed [31:0] c_q, s_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= 2'd0;
		end else if (x_pred) begin
			act_q <= 1'b1;
			cnt_q <= 2'd1;
		end else if (act_q) begin
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == 2'd3) act_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (x_pred) begin
			chan_q <= xi.chan;
			inr_q  <= x_inr;
			tap_q  <= taper_c;
			c_q    <= cos_pad[CORDIC_PAD-1];
			s_q    <= sin_pad[CORDIC_PAD-1];
		end
	end

	logic [AW-1:0] raddr, waddr;
	logic [47:0]   rdata;
	tag_t          iss_tag;
	logic          iss_v;

	assign waddr   = AW'({xi.chan, xi.pol});
	assign raddr   = x_pred ? AW'({xi.chan, 2'd0}) : AW'({chan_q, cnt_q});
	assign iss_v   = x_pred | act_q;

	always_comb begin
		if (x_pred) begin
			iss_tag.pol = 2'd0;
			iss_tag.inr = x_inr;
			iss_tag.tap = taper_c;
		end else begin
			iss_tag.pol = cnt_q;
			iss_tag.inr = inr_q;
			iss_tag.tap = tap_q;
		end
	end

	svp_ram #(
		.WIDTH (48),
		.DEPTH (CHANNELS * 4)
	) u_table (
		.clk   (clk),
		.we    (x_load),
		.waddr (waddr),
		.wdata ({xi.re, xi.im}),
		.raddr (raddr),
		.rdata (rdata)
	);

	// ---------------- rotate, taper, round, saturate ----------------
	logic v_s1r, v_s2, v_s3, v_s4, v_s5;
	tag_t tg_s1, tg_s2, tg_s3, tg_s4, tg_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1r <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
		end else begin
			v_s1r <= iss_v;
			v_s2  <= v_s1r;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		tg_s1 <= iss_tag;
		tg_s2 <= tg_s1;
		tg_s3 <= tg_s2;
		tg_s4 <= tg_s3;
		tg_s5 <= tg_s4;
	end

	// complex multiply by the phasor
	logic signed [23:0] br, bi;
	logic signed [55:0] pa, pb, pc, pd;
	logic signed [55:0] pa_s2, pb_s2, pc_s2, pd_s2;
	assign br = rdata[47:24];
	assign bi = rdata[23:0];
	assign pa = br * c_q;
	assign pb = bi * s_q;
	assign pc = br * s_q;
	assign pd = bi * c_q;

	logic signed [56:0] sr_s3, si_s3;

	always_ff @(posedge clk) begin
		pa_s2 <= pa;
		pb_s2 <= pb;
		pc_s2 <= pc;
		pd_s2 <= pd;
		sr_s3 <= 57'(pa_s2) - 57'(pb_s2);
		si_s3 <= 57'(pc_s2) + 57'(pd_s2);
	end

	// round half up to q8 for the taper path, to integer for a point source
	logic signed [57:0] sr22, si22, sr30, si30;
	assign sr22 = 58'(sr_s3) + 58'sd2097152;
	assign si22 = 58'(si_s3) + 58'sd2097152;
	assign sr30 = 58'(sr_s3) + 58'sd536870912;
	assign si30 = 58'(si_s3) + 58'sd536870912;

	logic signed [35:0] r22_s4, i22_s4;
	logic signed [27:0] r30_s4, i30_s4, r30_s5, i30_s5;
	logic signed [67:0] mr_s5, mi_s5;

	always_ff @(posedge clk) begin
		r22_s4 <= sr22[57:22];
		i22_s4 <= si22[57:22];
		r30_s4 <= sr30[57:30];
		i30_s4 <= si30[57:30];
		mr_s5  <= r22_s4 * signed'({1'b0, tg_s4.tap});
		mi_s5  <= i22_s4 * signed'({1'b0, tg_s4.tap});
		r30_s5 <= r30_s4;
		i30_s5 <= i30_s4;
	end

	function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
		if (v > 40'sd8388607) return 24'sd8388607;
		if (v < -40'sd8388608) return -24'sd8388608;
		return 24'(v);
	endfunction

	logic signed [68:0] gr, gi;
	logic signed [39:0] fr, fi;
	assign gr = 69'(mr_s5) + 69'sd137438953472;
	assign gi = 69'(mi_s5) + 69'sd137438953472;

	// gaussian: round off 38 bits, keeping the sign; point: already integer; channel out of range: zero
	always_comb begin
		if (!tg_s5.inr) begin
			fr = '0;
			fi = '0;
		end else if (kind_q) begin
			fr = 40'(signed'(gr[68:38]));
			fi = 40'(signed'(gi[68:38]));
		end else begin
			fr = 40'(r30_s5);
			fi = 40'(i30_s5);
		end
	end

	svp_out_t res_q;
	logic     res_strobe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_strobe_q <= 1'b0;
		else res_strobe_q <= v_s5;
	end

	always_ff @(posedge clk) begin
		res_q <= '{pol_out: tg_s5.pol, vis_re: sat24(fr), vis_im: sat24(fi),
			last: (tg_s5.pol == 2'd3)};
	end

	assign res        = res_q;
	assign res_strobe = res_strobe_q;

endmodule

/* design/svp_checker.sv */
// port-level checker for the source visibility predictor, bound to the top level
// depends on svp_pkg and source_visibility_predictor
module svp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input svp_pkg::svp_in_t  item,
	input logic              res_strobe,
	input svp_pkg::svp_out_t res
);
	import svp_pkg::*;

	// a predict word holds the input off with busy, which then falls again
	a_predict_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.op == OP_PREDICT) |=> busy ##1 busy ##1 busy ##1 !busy)
		else $error("busy window after predict is wrong");

	// a load word never blocks the next one
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.op == OP_LOAD) |=> !busy)
		else $error("busy after load word");

	// result words of a burst come in polarization order, back to back
	a_pol_order: assert property (@(posedge clk) disable iff (!arst_n)
		(res_strobe && res.pol_out != 2'd0) |->
		($past(res_strobe) && ($past(res.pol_out) + 2'd1 == res.pol_out)))
		else $error("result polarization out of order");

	a_last_pol: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe |-> (res.last == (res.pol_out == 2'd3)))
		else $error("last marks the wrong word");

	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(res_strobe && !res.last) |=> res_strobe)
		else $error("result burst broken");

endmodule

bind source_visibility_predictor svp_checker u_svp_checker (.*);

/* tb/sv/source_visibility_predictor_test.sv */
// self-checking testbench for the source visibility predictor
// depends on svp_pkg and source_visibility_predictor; loads a brightness table, predicts
// visibilities under several position and taper settings, checks every result word
`timescale 1ns / 1ps

module source_visibility_predictor_test;
	import svp_pkg::*;

	localparam int CHANNELS   = 256;
	localparam int DRAIN_WAIT = 70;   // longer than the predict latency

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	svp_in_t           item = '0;
	logic              res_strobe;
	svp_out_t          res;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [2:0]        cfg_index = '0;
	logic [31:0]       cfg_data = '0;

	source_visibility_predictor #(.CHANNELS(CHANNELS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.res_strobe(res_strobe), .res(res), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// command words waiting for the driver, and visibility words waiting for the monitor
	svp_in_t  cmd_pending[$];
	svp_out_t vis_expected[$];

	// predictor copy of the brightness table and registers
	logic signed [23:0] bright_re_tab [CHANNELS*4];
	logic signed [23:0] bright_im_tab [CHANNELS*4];
	longint pos_l, pos_m, pos_n1;
	longint gauss_t [4];
	bit     gaussian;

	// generation side bookkeeping: which entries are loaded, which channels are complete
	bit     gen_loaded [CHANNELS*4];
	int     full_chans[$];

	int     idle_pct = 0;
	int     errors = 0;
	int     n_loads = 0;
	int     n_predicts = 0;
	int     n_words = 0;

	// ---------------------------------------------------------------- arithmetic helpers

	function automatic longint rnd_shift(longint x, int s);
		return (x + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [23:0] clip24(longint x);
		if (x > 8388607) return 24'sd8388607;
		if (x < -8388608) return -24'sd8388608;
		return x[23:0];
	endfunction

	function automatic longint clamp_16(longint x);
		if (x > (longint'(1) <<< 28)) return longint'(1) <<< 28;
		if (x < -(longint'(1) <<< 28)) return -(longint'(1) <<< 28);
		return x;
	endfunction

	// cosine and sine in q30 of a 32 bit phase in turns, quarter turn fold then 28 steps
	task automatic phase_to_cos_sin(input logic [31:0] phase, output longint c,
			output longint s);
		longint p, x, y, z, dx, dy;
		bit     flip;
		p = longint'(signed'(phase));
		flip = 0;
		x = CORDIC_GAIN_Q30;
		y = 0;
		if (p > (longint'(1) <<< 30)) begin
			p = p - (longint'(1) <<< 31);
			flip = 1;
		end else if (p < -(longint'(1) <<< 30)) begin
			p = p + (longint'(1) <<< 31);
			flip = 1;
		end
		z = p;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - longint'(ATAN_TURNS[i]);
			end else begin
				x = x + dx; y = y - dy; z = z + longint'(ATAN_TURNS[i]);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	// gaussian taper exp(-(ut^2+vt^2)) in q30
	function automatic longint gauss_taper(longint u, longint v);
		longint ut, vt, acc;
		longint unsigned q, y, k, f, t, term;
		ut = clamp_16(((u * gauss_t[0]) >>> 32) + ((v * gauss_t[1]) >>> 32));
		vt = clamp_16(((u * gauss_t[2]) >>> 32) + ((v * gauss_t[3]) >>> 32));
		q = (longint'(unsigned'(ut * ut)) + longint'(unsigned'(vt * vt)));
		q = q >> 24;
		// argument of 32 or more gives a zero taper
		if (q >= (64'd1 << 29)) return 0;
		y = (q * 64'(LOG2E_Q30)) >> 30;
		k = y >> 24;
		f = y & 64'hFF_FFFF;
		if (k >= 31) return 0;
		t = ((f << 6) * 64'(LN2_Q30)) >> 30;
		term = 64'(ONE_Q30);
		acc = longint'(ONE_Q30);
		for (int n = 1; n <= 13; n++) begin
			term = ((term * t) >> 30) / n;
			if (n % 2) acc = acc - longint'(term);
			else acc = acc + longint'(term);
		end
		return longint'(longint'(unsigned'(acc)) >> k);
	endfunction

	// apply one accepted command word to the predictor
	task automatic predict_word(input svp_in_t w);
		longint u, v, wc, c, s, taper, br, bi, sr, si, re, im;
		logic [63:0] phase_acc;
		int idx;
		svp_out_t o;
		if (w.op == OP_LOAD) begin
			n_loads++;
			// a channel past the table is dropped
			if (w.chan < CHANNELS) begin
				bright_re_tab[w.chan*4 + w.pol_in] = w.bright_re;
				bright_im_tab[w.chan*4 + w.pol_in] = w.bright_im;
			end
			return;
		end
		n_predicts++;
		u = longint'(w.coord_u);
		v = longint'(w.coord_v);
		wc = longint'(w.coord_w);
		phase_acc = u * pos_l + v * pos_m + wc * pos_n1;
		phase_to_cos_sin(phase_acc[45:14], c, s);
		taper = gaussian ? gauss_taper(u, v) : 0;
		for (int p = 0; p < 4; p++) begin
			re = 0;
			im = 0;
			if (w.chan < CHANNELS) begin
				idx = w.chan*4 + p;
				br = longint'(bright_re_tab[idx]);
				bi = longint'(bright_im_tab[idx]);
				sr = br * c - bi * s;
				si = br * s + bi * c;
				if (gaussian) begin
					re = rnd_shift(rnd_shift(sr, 22) * taper, 38);
					im = rnd_shift(rnd_shift(si, 22) * taper, 38);
				end else begin
					re = rnd_shift(sr, 30);
					im = rnd_shift(si, 30);
				end
			end
			o.pol_out = p[1:0];
			o.vis_re = clip24(re);
			o.vis_im = clip24(im);
			o.last = (p == 3);
			vis_expected = {vis_expected, o};
		end
	endtask

	// ---------------------------------------------------------------- driver

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				predict_word(item);
			// the word in flight is held until accepted; otherwise pick the next one
			if (!start || !busy) begin
				if (cmd_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
					item <= cmd_pending.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin
		svp_out_t want;
		if (arst_n && res_strobe) begin
			n_words++;
			if (vis_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word pol %0d re %0d im %0d last %0b",
					$realtime, res.pol_out, res.vis_re, res.vis_im, res.last);
			end else begin
				want = vis_expected.pop_front();
				if (res.pol_out !== want.pol_out) begin
					errors++;
					$display("%0t: pol_out expected %0d actual %0d", $realtime,
						want.pol_out, res.pol_out);
				end
				if (res.vis_re !== want.vis_re) begin
					errors++;
					$display("%0t: vis_re expected %0d actual %0d", $realtime,
						want.vis_re, res.vis_re);
				end
				if (res.vis_im !== want.vis_im) begin
					errors++;
					$display("%0t: vis_im expected %0d actual %0d", $realtime,
						want.vis_im, res.vis_im);
				end
				if (res.last !== want.last) begin
					errors++;
					$display("%0t: last expected %0b actual %0b", $realtime,
						want.last, res.last);
				end
			end
		end
	end

	// ---------------------------------------------------------------- stimulus helpers

	task automatic write_reg(input svp_reg_t idx, input logic [31:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_POS_L:       pos_l = longint'(signed'(d[30:0]));
			REG_POS_M:       pos_m = longint'(signed'(d[30:0]));
			REG_POS_N1:      pos_n1 = longint'(signed'(d[30:0]));
			REG_GAUSS_T0:    gauss_t[0] = longint'(signed'(d));
			REG_GAUSS_T1:    gauss_t[1] = longint'(signed'(d));
			REG_GAUSS_T2:    gauss_t[2] = longint'(signed'(d));
			REG_GAUSS_T3:    gauss_t[3] = longint'(signed'(d));
			REG_SOURCE_KIND: gaussian = d[0];
			default: ;
		endcase
	endtask

	task automatic set_source(input logic [31:0] l, m, n1, t0, t1, t2, t3,
			input bit kind);
		write_reg(REG_POS_L, l);
		write_reg(REG_POS_M, m);
		write_reg(REG_POS_N1, n1);
		write_reg(REG_GAUSS_T0, t0);
		write_reg(REG_GAUSS_T1, t1);
		write_reg(REG_GAUSS_T2, t2);
		write_reg(REG_GAUSS_T3, t3);
		write_reg(REG_SOURCE_KIND, {31'd0, kind});
	endtask

	function automatic void queue_load(logic [7:0] chan, logic [1:0] pol,
			logic [23:0] re, im);
		svp_in_t w;
		w.op = OP_LOAD;
		w.chan = chan;
		w.pol_in = pol;
		w.bright_re = re;
		w.bright_im = im;
		w.coord_u = $urandom;
		w.coord_v = $urandom;
		w.coord_w = $urandom;
		cmd_pending = {cmd_pending, w};
		gen_loaded[chan*4 + pol] = 1;
		if (gen_loaded[chan*4] && gen_loaded[chan*4+1] && gen_loaded[chan*4+2] &&
				gen_loaded[chan*4+3]) begin
			foreach (full_chans[i])
				if (full_chans[i] == chan) return;
			full_chans = {full_chans, int'(chan)};
		end
	endfunction

	function automatic void queue_predict(logic [7:0] chan, logic [31:0] u, v, w_c);
		svp_in_t w;
		w.op = OP_PREDICT;
		w.chan = chan;
		w.pol_in = 2'($urandom);
		w.bright_re = 24'($urandom);
		w.bright_im = 24'($urandom);
		w.coord_u = u;
		w.coord_v = v;
		w.coord_w = w_c;
		cmd_pending = {cmd_pending, w};
	endfunction

	// coordinate: mostly full range, some small enough for a non-trivial taper
	function automatic logic [31:0] rand_coord();
		if ($urandom_range(99) < 35)
			return 32'($signed($urandom_range(2097152)) - 1048576);
		return $urandom;
	endfunction

	// random mix: well-formed load groups and predicts on complete channels, some stray loads
	function automatic void queue_random(int n);
		int r;
		logic [7:0] ch;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 8) begin
				ch = 8'($urandom);
				for (int p = 0; p < 4; p++)
					queue_load(ch, p[1:0], 24'($urandom), 24'($urandom));
			end else if (r < 20) begin
				queue_load(8'($urandom), 2'($urandom), 24'($urandom), 24'($urandom));
			end else begin
				queue_predict(8'(full_chans[$urandom_range(full_chans.size() - 1)]),
					rand_coord(), rand_coord(), rand_coord());
			end
		end
	endfunction

	// sender holds off until the last result word has come and the pipe is empty
	task automatic drain();
		while (cmd_pending.size() > 0 || start || vis_expected.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- test sequence

	initial begin
		pos_l = 0; pos_m = 0; pos_n1 = 0;
		foreach (gauss_t[i]) gauss_t[i] = 0;
		gaussian = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: point source at the phase center, extreme brightness and coordinates
		idle_pct = 26;
		set_source(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
		queue_load(8'd0, 2'd0, 24'h7FFFFF, 24'h800000);
		queue_load(8'd0, 2'd1, 24'h800000, 24'h7FFFFF);
		queue_load(8'd0, 2'd2, 24'h000000, 24'hFFFFFF);
		queue_load(8'd0, 2'd3, 24'h7FFFFF, 24'h7FFFFF);
		queue_load(8'd255, 2'd0, 24'h800000, 24'h800000);
		queue_load(8'd255, 2'd1, 24'h000001, 24'hFFFFFF);
		queue_load(8'd255, 2'd2, 24'h123456, 24'hEDCBA9);
		queue_load(8'd255, 2'd3, 24'h7FFFFF, 24'h000000);
		queue_predict(8'd0, 32'd0, 32'd0, 32'd0);
		queue_predict(8'd255, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
		drain();

		// extreme positions, so the phase wraps and crosses the quarter turn folds
		set_source(32'h3FFFFFFF, 32'h40000000, 32'h40000000, 32'd0, 32'd0, 32'd0, 32'd0,
			1'b0);
		queue_predict(8'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
		queue_predict(8'd255, 32'h80000000, 32'h00000000, 32'h7FFFFFFF);
		queue_predict(8'd0, 32'h00008000, 32'h00000000, 32'h00000000);
		queue_predict(8'd255, 32'h00010000, 32'hFFFF0000, 32'h00004000);
		queue_random(40);
		drain();

		// gaussian with extreme transform: clamped and vanishing tapers
		idle_pct = 64;
		set_source(32'h00100000, 32'h7FF00000, 32'h7FFFF000, 32'h7FFFFFFF, 32'h80000000,
			32'h80000000, 32'h7FFFFFFF, 1'b1);
		queue_predict(8'd0, 32'd0, 32'd0, 32'd0);
		queue_predict(8'd0, 32'h7FFFFFFF, 32'h80000000, 32'h00000001);
		queue_predict(8'd255, 32'h00000100, 32'h00000200, 32'h00000000);
		queue_random(40);
		drain();

		// gaussian with random moderate transform, taper mostly between zero and one
		set_source($urandom, $urandom, 32'($signed(0) - $signed($urandom_range(1 << 30))),
			32'($signed($urandom_range(1 << 24)) - (1 << 23)), $urandom_range(1 << 20),
			$urandom_range(1 << 20), 32'($signed($urandom_range(1 << 24)) - (1 << 23)), 1'b1);
		queue_random(45);
		drain();

		// back to a point source, random position, no idling on the sender
		idle_pct = 0;
		set_source($urandom, $urandom, 32'($signed(0) - $signed($urandom_range(1 << 30))),
			$urandom, $urandom, $urandom, $urandom, 1'b0);
		queue_random(45);
		drain();

		$display("covered %0d loads and %0d predicts, %0d result words, point and gaussian",
			n_loads, n_predicts, n_words);
		$display("sources with extreme and random positions and transforms");
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

/* sim.f */
design/svp_pkg.sv
design/svp_ram.sv
design/svp_cordic.sv
design/svp_taper.sv
design/source_visibility_predictor.sv
design/svp_checker.sv
tb/sv/source_visibility_predictor_test.sv
